// File: hw/rtl/hvlc_pkg.sv
package hvlc_pkg;

    localparam int MAX_CODE_BITS = 63;
    localparam int WORD_W        = MAX_CODE_BITS;
    localparam int LEN_W         = 6;
    localparam int SYN_W         = 6;
    localparam int DATA_MAX      = 57;   // data bits that fit in a 63-bit codeword

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CORRECTED = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_BAD_LEN   = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [LEN_W-1:0]  length;
        logic [WORD_W-1:0] word;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic [LEN_W-1:0]  result_length;
        logic [SYN_W-1:0]  syndrome;
        logic [1:0]        status;
    } rsp_t;

    function automatic logic is_pow2(int unsigned v);
        return (v != 0) && ((v & (v - 1)) == 0);
    endfunction

    // code positions (1-based) whose index has bit i set
    function automatic logic [WORD_W-1:0] pos_mask(int unsigned i);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int q = 1; q <= WORD_W; q++)
        begin
            if (((q >> i) & 1) != 0)
                m[q-1] = 1'b1;
        end
        return m;
    endfunction

    // data bit index carried at a non-power-of-two code position
    function automatic int unsigned data_idx(int unsigned q);
        int unsigned n_pow;
        n_pow = 0;
        for (int b = 0; b < 32; b++)
        begin
            if ((1 << b) <= q)
                n_pow++;
        end
        return q - 1 - n_pow;
    endfunction

    // code position (1-based) of data bit j
    function automatic int unsigned data_pos(int unsigned j);
        int unsigned cnt;
        int unsigned r;
        cnt = 0;
        r   = 0;
        for (int q = 1; q <= WORD_W; q++)
        begin
            if (!is_pow2(q))
            begin
                if (cnt == j)
                    r = q;
                cnt++;
            end
        end
        return r;
    endfunction

    // number of significant bits, i.e. powers of two not above v
    function automatic logic [2:0] bit_length(logic [LEN_W-1:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int b = 0; b < LEN_W; b++)
        begin
            if (v[b])
                r = 3'(b + 1);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/hvlc_req_if.sv
interface hvlc_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [hvlc_pkg::LEN_W-1:0]   length;
    logic [hvlc_pkg::WORD_W-1:0]  word;

    modport source (output valid, mode, length, word, input ready);
    modport sink   (input valid, mode, length, word, output ready);
endinterface

// File: hw/rtl/hvlc_rsp_if.sv
interface hvlc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hvlc_pkg::WORD_W-1:0]  result_word;
    logic [hvlc_pkg::LEN_W-1:0]   result_length;
    logic [hvlc_pkg::SYN_W-1:0]   syndrome;
    logic [1:0]                   status;

    modport source (output valid, result_word, result_length, syndrome, status, input ready);
    modport sink   (input valid, result_word, result_length, syndrome, status, output ready);
endinterface

// File: hw/rtl/hamming_variable_length_codec_unit.sv
// Hamming single-error-correcting codec with a block length chosen per word.
// mode 0 encodes length data bits (1..57) into a codeword of length + p bits,
// p the smallest count with 2^p > length + p; mode 1 checks a codeword of
// length bits, flips the bit named by a nonzero syndrome that lies inside the
// word, and returns the data bits. status: 0 ok, 1 corrected, 2 syndrome past
// the end of the word (nothing flipped), 3 bad length (all other fields zero).
// Bits of word at or above length are ignored. A word passes two registers (input
// register, then the codec logic into the result register); one word is
// accepted every cycle while the result side keeps up, and the result register
// lets a new word enter while the previous result waits.
module hamming_variable_length_codec_unit
(
    input  logic        clk,
    input  logic        rst_n,
    hvlc_req_if.sink    din,
    hvlc_rsp_if.source  dout
);

    logic           s1_valid_reg;
    hvlc_pkg::req_t s1_req_reg;
    logic           out_valid_reg;
    hvlc_pkg::rsp_t out_rsp_reg;
    hvlc_pkg::rsp_t core_rsp;
    logic           out_free;
    logic           s1_free;

    assign out_free  = !out_valid_reg || dout.ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign din.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= din.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && din.valid)
        begin
            s1_req_reg.mode   <= din.mode;
            s1_req_reg.length <= din.length;
            s1_req_reg.word   <= din.word;
        end
        if (out_free && s1_valid_reg)
            out_rsp_reg <= core_rsp;
    end

    hvlc_core u_core
    (
        .req (s1_req_reg),
        .rsp (core_rsp)
    );

    assign dout.valid         = out_valid_reg;
    assign dout.result_word   = out_rsp_reg.result_word;
    assign dout.result_length = out_rsp_reg.result_length;
    assign dout.syndrome      = out_rsp_reg.syndrome;
    assign dout.status        = out_rsp_reg.status;

    a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rsp_reg.status == hvlc_pkg::ST_BAD_LEN)
        |-> (out_rsp_reg.result_word == '0 && out_rsp_reg.result_length == '0
             && out_rsp_reg.syndrome == '0))
        else $error("bad length word carries data");

    a_ok_no_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rsp_reg.status == hvlc_pkg::ST_OK)
        |-> (out_rsp_reg.syndrome == '0))
        else $error("ok status with nonzero syndrome");

    a_corrected_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_rsp_reg.status == hvlc_pkg::ST_CORRECTED
                           || out_rsp_reg.status == hvlc_pkg::ST_BEYOND))
        |-> (out_rsp_reg.syndrome != '0))
        else $error("error status with zero syndrome");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !out_valid_reg) |-> din.ready)
        else $error("empty pipeline refuses input");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("word lost between stages");

endmodule

// File: hw/rtl/hvlc_core.sv
module hvlc_core
(
    input  hvlc_pkg::req_t req,
    output hvlc_pkg::rsp_t rsp
);

    logic [hvlc_pkg::WORD_W-1:0] masked;
    logic [hvlc_pkg::WORD_W-1:0] scatter;
    logic [hvlc_pkg::WORD_W-1:0] enc_word;
    logic [hvlc_pkg::SYN_W-1:0]  enc_syn;
    logic [2:0]                  p_sel;
    logic [hvlc_pkg::LEN_W:0]    n_enc;
    logic [hvlc_pkg::SYN_W-1:0]  dec_syn;
    logic [hvlc_pkg::WORD_W-1:0] flip_vec;
    logic [hvlc_pkg::WORD_W-1:0] corrected;
    logic [hvlc_pkg::WORD_W-1:0] gathered;
    logic [hvlc_pkg::LEN_W-1:0]  dec_k;
    logic                        in_range;

    always_comb
    begin
        for (int b = 0; b < hvlc_pkg::WORD_W; b++)
            masked[b] = req.word[b] && (b < int'(req.length));

        // encode: data into non-power-of-two positions, parity into the rest
        scatter = '0;
        for (int q = 1; q <= hvlc_pkg::WORD_W; q++)
        begin
            if (!hvlc_pkg::is_pow2(q))
                scatter[q-1] = masked[hvlc_pkg::data_idx(q)];
        end
        enc_word = scatter;
        for (int i = 0; i < hvlc_pkg::SYN_W; i++)
        begin
            enc_syn[i] = ^(scatter & hvlc_pkg::pos_mask(i));
            enc_word[(1 << i) - 1] = enc_syn[i];
        end

        // smallest p with 2^p > k + p; 7 marks "does not fit"
        p_sel = 3'd7;
        for (int p = hvlc_pkg::SYN_W; p >= 1; p--)
        begin
            if (({1'b0, req.length} + 7'(p)) < 7'(1 << p))
                p_sel = 3'(p);
        end
        n_enc = {1'b0, req.length} + {4'b0, p_sel};

        // decode
        for (int i = 0; i < hvlc_pkg::SYN_W; i++)
            dec_syn[i] = ^(masked & hvlc_pkg::pos_mask(i));
        in_range  = (dec_syn != '0) && (dec_syn <= req.length);
        flip_vec  = in_range ? (hvlc_pkg::WORD_W'(1) << (dec_syn - 6'd1)) : '0;
        corrected = masked ^ flip_vec;
        gathered  = '0;
        for (int j = 0; j < hvlc_pkg::DATA_MAX; j++)
            gathered[j] = corrected[hvlc_pkg::data_pos(j) - 1];
        dec_k = req.length - {3'b0, hvlc_pkg::bit_length(req.length)};

        rsp.result_word   = '0;
        rsp.result_length = '0;
        rsp.syndrome      = '0;
        rsp.status        = hvlc_pkg::ST_BAD_LEN;
        if (req.length != '0)
        begin
            if (req.mode == hvlc_pkg::MODE_ENCODE)
            begin
                if (n_enc <= 7'(hvlc_pkg::MAX_CODE_BITS))
                begin
                    rsp.result_word   = enc_word;
                    rsp.result_length = n_enc[hvlc_pkg::LEN_W-1:0];
                    rsp.status        = hvlc_pkg::ST_OK;
                end
            end
            else
            begin
                rsp.result_word   = gathered;
                rsp.result_length = dec_k;
                rsp.syndrome      = dec_syn;
                if (dec_syn == '0)
                    rsp.status = hvlc_pkg::ST_OK;
                else if (in_range)
                    rsp.status = hvlc_pkg::ST_CORRECTED;
                else
                    rsp.status = hvlc_pkg::ST_BEYOND;
            end
        end
    end

endmodule
